// ----- sv/ppm_pkg.sv -----
// Package: shared types, constants and codes of the PPM to RGB332 decoder.
`timescale 1ns / 1ps
package ppm_pkg;
   localparam int unsigned MAX_PIXELS_DEF = 16777216;
   localparam int unsigned NUM_W = 25;
   localparam logic [NUM_W-1:0] NUM_SAT = '1;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_MAGIC  = 3'd0;
   localparam logic [2:0] ERR_HDR    = 3'd1;
   localparam logic [2:0] ERR_DIM    = 3'd2;
   localparam logic [2:0] ERR_SHORT  = 3'd3;
   localparam logic [2:0] ERR_SAMPLE = 3'd4;

   localparam logic [2:0] PH_MAGIC  = 3'd0;
   localparam logic [2:0] PH_WIDTH  = 3'd1;
   localparam logic [2:0] PH_HEIGHT = 3'd2;
   localparam logic [2:0] PH_MAXVAL = 3'd3;
   localparam logic [2:0] PH_BIN    = 3'd4;
   localparam logic [2:0] PH_ASCII  = 3'd5;
   localparam logic [2:0] PH_ERROR  = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   localparam logic [1:0] MP_NONE = 2'd0;
   localparam logic [1:0] MP_P    = 2'd1;
   localparam logic [1:0] MP_OK   = 2'd2;
   localparam logic [1:0] MP_BAD  = 2'd3;

   // parser context held in the state memory
   typedef struct packed {
      logic [2:0]       phase;
      logic             binary;
      logic [1:0]       magic;
      logic             comment;
      logic             token;
      logic             invalid;
      logic [NUM_W-1:0] accum;
      logic [NUM_W-1:0] width;
      logic [NUM_W-1:0] height;
      logic [7:0]       maxval;
      logic [NUM_W-1:0] left;
      logic [1:0]       comp;
      logic [2:0]       red;
      logic [2:0]       green;
   } ctx_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       pixel;
      logic             last;
      logic [NUM_W-1:0] width;
      logic [NUM_W-1:0] height;
      logic [2:0]       code;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic ctx_type ctx_reset();
      ctx_type c;
      c = '0;
      c.phase = PH_MAGIC;
      return c;
   endfunction
endpackage

// ----- sv/ppm_div.sv -----
// Iterative restoring divider: quotient of a 16-bit numerator by an 8-bit divisor.
`timescale 1ns / 1ps
module ppm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] num,
   input  logic [7:0]  den,
   output logic        done,
   output logic [7:0]  quot
);
   logic [15:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [7:0]  d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[15]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial[7:0] - d_ff;
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = trial[7:0];
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff[7:0];
endmodule

// ----- sv/ppm_ctx_mem.sv -----
// Single-entry synchronous state memory holding the parser context.
`timescale 1ns / 1ps
module ppm_ctx_mem (
   input  logic             clock,
   input  logic             wr_en,
   input  ppm_pkg::ctx_type wr_data,
   output ppm_pkg::ctx_type rd_data
);
   ppm_pkg::ctx_type mem [1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[0] <= wr_data;
      end
      rd_data <= mem[0];
   end
endmodule

// ----- sv/ppm_to_rgb332_decoder.sv -----
// Top level: PPM P3/P6 byte-stream decoder producing RGB332 pixels.
// channel | direction | ports
// req     | in        | req_valid req_stall req_data_byte req_first_byte req_end_of_file
// rsp     | out       | rsp_valid rsp_stall rsp_kind rsp_pixel_value rsp_last_pixel
//         |           | rsp_image_width rsp_image_height rsp_error_code
// Text bytes pass through accept, memory read, update and write back; a maxval end adds the area check.
// Bytes that complete a sample also pass through the bit-serial divider.
// The context lives in a one-entry memory; a memory read precedes each word.
// Reset clears control; the memory is written with the reset context during reset.
// A waiting result holds only the write back; the request side stalls on busy alone.
`timescale 1ns / 1ps
module ppm_to_rgb332_decoder #(
   parameter int unsigned MAX_PIXELS = ppm_pkg::MAX_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_last_pixel,
   output logic [24:0] rsp_image_width,
   output logic [24:0] rsp_image_height,
   output logic [2:0]  rsp_error_code
);
   localparam int unsigned NW = ppm_pkg::NUM_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_EXEC = 6'b000100,
      ST_AREA = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_WRIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] byte_ff;
   logic       first_ff, eof_ff;
   ppm_pkg::ctx_type ctx_ff, ctx_in, mem_rd, wr_data;
   logic       wr_en;
   ppm_pkg::rsp_type res_ff, res_in, out_ff, out_in;
   logic       res_v_ff, res_v_in;
   logic       out_v_ff, out_v_in;
   logic [49:0] area_ff;
   logic [7:0] samp_ff, samp_in;
   logic       need_div_ff, need_div_in;
   logic       need_area_ff, need_area_in;
   logic       div_start, div_done;
   logic [7:0] div_q;
   logic [15:0] div_num;

   function automatic ppm_pkg::rsp_type mk_err(input logic [2:0] code);
      ppm_pkg::rsp_type r;
      r = '0;
      r.kind = ppm_pkg::KIND_ERROR;
      r.code = code;
      return r;
   endfunction

   ppm_ctx_mem u_mem (
      .clock(clock), .wr_en(wr_en), .wr_data(wr_data), .rd_data(mem_rd)
   );

   assign div_num = {8'd0, samp_in} * 16'd255;
   ppm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(ctx_in.maxval), .done(div_done), .quot(div_q)
   );

   // state machine and context update for every state; touches c, r, rv
   // header area check is deferred to ST_AREA
   always_comb begin
      ppm_pkg::ctx_type c;
      ppm_pkg::rsp_type r;
      logic rv;
      logic [NW+3:0] v;
      logic tok_end;
      logic [7:0] s;
      logic [2:0] code;
      c = ctx_ff;
      r = res_ff;
      rv = res_v_ff;
      state_in = state_ff;
      samp_in = samp_ff;
      need_div_in = need_div_ff;
      need_area_in = need_area_ff;
      div_start = 1'b0;
      wr_en = 1'b0;
      wr_data = ctx_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      tok_end = 1'b0;
      v = '0;
      s = '0;
      code = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            c = first_ff ? ppm_pkg::ctx_reset() : mem_rd;
            rv = 1'b0;
            r = '0;
            need_div_in = 1'b0;
            need_area_in = 1'b0;
            if (c.phase < ppm_pkg::PH_ERROR) begin
               if (c.phase == ppm_pkg::PH_BIN) begin
                  samp_in = byte_ff;
                  need_div_in = 1'b1;
               end else if (c.comment) begin
                  if (byte_ff == 8'h0A) c.comment = 1'b0;
               end else if (!c.token) begin
                  if (byte_ff == 8'h23) c.comment = 1'b1;
                  else if (!ppm_pkg::is_space(byte_ff)) begin
                     c.token = 1'b1;
                     c.invalid = 1'b0;
                     c.accum = '0;
                     c.magic = ppm_pkg::MP_NONE;
                  end
               end else if (ppm_pkg::is_space(byte_ff)) begin
                  tok_end = 1'b1;
               end
               if (c.phase != ppm_pkg::PH_BIN && c.token && !tok_end) begin
                  if (c.phase == ppm_pkg::PH_MAGIC) begin
                     if (c.magic == ppm_pkg::MP_NONE)
                        c.magic = (byte_ff == 8'h50) ? ppm_pkg::MP_P : ppm_pkg::MP_BAD;
                     else if (c.magic == ppm_pkg::MP_P) begin
                        if (byte_ff == 8'h33 || byte_ff == 8'h36) begin
                           c.magic = ppm_pkg::MP_OK;
                           c.binary = (byte_ff == 8'h36);
                        end else c.magic = ppm_pkg::MP_BAD;
                     end else c.magic = ppm_pkg::MP_BAD;
                  end else if (ppm_pkg::is_digit(byte_ff)) begin
                     v = {4'd0, c.accum} * (NW+4)'(10) + (NW+4)'(byte_ff - 8'h30);
                     c.accum = (v > {4'd0, ppm_pkg::NUM_SAT}) ? ppm_pkg::NUM_SAT : v[NW-1:0];
                  end else c.invalid = 1'b1;
               end
               if (eof_ff && c.token && !tok_end) tok_end = 1'b1;
               if (tok_end) begin
                  c.token = 1'b0;
                  case (c.phase)
                     ppm_pkg::PH_MAGIC: begin
                        if (c.magic == ppm_pkg::MP_OK) c.phase = ppm_pkg::PH_WIDTH;
                        else begin
                           c.phase = ppm_pkg::PH_ERROR;
                           c.comment = 1'b0;
                           rv = 1'b1;
                           r = mk_err(ppm_pkg::ERR_MAGIC);
                        end
                     end
                     ppm_pkg::PH_WIDTH, ppm_pkg::PH_HEIGHT: begin
                        if (c.invalid) begin
                           c.phase = ppm_pkg::PH_ERROR;
                           c.comment = 1'b0;
                           rv = 1'b1;
                           r = mk_err(ppm_pkg::ERR_HDR);
                        end else if (c.phase == ppm_pkg::PH_WIDTH) begin
                           c.width = c.accum;
                           c.phase = ppm_pkg::PH_HEIGHT;
                        end else begin
                           c.height = c.accum;
                           c.phase = ppm_pkg::PH_MAXVAL;
                        end
                     end
                     ppm_pkg::PH_MAXVAL: begin
                        if (c.invalid) begin
                           c.phase = ppm_pkg::PH_ERROR;
                           c.comment = 1'b0;
                           rv = 1'b1;
                           r = mk_err(ppm_pkg::ERR_HDR);
                        end else need_area_in = 1'b1;
                     end
                     ppm_pkg::PH_ASCII: begin
                        if (c.invalid) begin
                           c.phase = ppm_pkg::PH_ERROR;
                           c.comment = 1'b0;
                           rv = 1'b1;
                           r = mk_err(ppm_pkg::ERR_SAMPLE);
                        end else begin
                           samp_in = (c.accum > NW'(c.maxval)) ? c.maxval : c.accum[7:0];
                           need_div_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            if (c.phase == ppm_pkg::PH_BIN && byte_ff > c.maxval) samp_in = c.maxval;
            if (need_div_in) state_in = ST_DIV;
            else if (need_area_in) state_in = ST_AREA;
            else state_in = ST_WRIT;
            if (need_div_in) div_start = 1'b1;
         end
         ST_AREA: begin
            if (ctx_ff.width == '0 || ctx_ff.height == '0 || ctx_ff.accum == '0 ||
                ctx_ff.accum > NW'(255) || area_ff > 50'(MAX_PIXELS)) begin
               c.phase = ppm_pkg::PH_ERROR;
               c.comment = 1'b0;
               rv = 1'b1;
               r = mk_err(ppm_pkg::ERR_DIM);
            end else begin
               c.maxval = ctx_ff.accum[7:0];
               c.left = area_ff[NW-1:0];
               c.comp = '0;
               c.phase = ctx_ff.binary ? ppm_pkg::PH_BIN : ppm_pkg::PH_ASCII;
               rv = 1'b1;
               r = '0;
               r.kind = ppm_pkg::KIND_HEADER;
               r.width = ctx_ff.width;
               r.height = ctx_ff.height;
            end
            state_in = ST_WRIT;
         end
         ST_DIV: begin
            if (div_done) begin
               s = div_q;
               if (ctx_ff.comp == 2'd0) begin
                  c.red = s[7:5];
                  c.comp = 2'd1;
               end else if (ctx_ff.comp == 2'd1) begin
                  c.green = s[7:5];
                  c.comp = 2'd2;
               end else begin
                  c.comp = 2'd0;
                  c.left = ctx_ff.left - NW'(1);
                  rv = 1'b1;
                  r = '0;
                  r.kind = ppm_pkg::KIND_PIXEL;
                  r.pixel = {ctx_ff.red, ctx_ff.green, s[7:6]};
                  r.last = (c.left == '0);
                  if (c.left == '0) c.phase = ppm_pkg::PH_DONE;
               end
               state_in = ST_WRIT;
            end
         end
         ST_WRIT: begin
            if (!out_v_ff || !rsp_stall) begin
               if (eof_ff && ctx_ff.phase < ppm_pkg::PH_ERROR) begin
                  code = (ctx_ff.phase == ppm_pkg::PH_MAGIC) ? ppm_pkg::ERR_MAGIC :
                         (ctx_ff.phase <= ppm_pkg::PH_MAXVAL) ? ppm_pkg::ERR_HDR :
                         ppm_pkg::ERR_SHORT;
                  c.phase = ppm_pkg::PH_ERROR;
                  c.token = 1'b0;
                  c.comment = 1'b0;
                  rv = 1'b1;
                  r = mk_err(code);
               end
               wr_en = 1'b1;
               wr_data = c;
               out_in = r;
               out_v_in = rv;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ctx_in = c;
      res_in = r;
      res_v_in = rv;
      if (reset) begin
         wr_en = 1'b1;
         wr_data = ppm_pkg::ctx_reset();
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         res_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         res_v_ff <= res_v_in;
      end
      if (state_ff == ST_IDLE) begin
         byte_ff <= req_data_byte;
         first_ff <= req_first_byte;
         eof_ff <= req_end_of_file;
      end
      ctx_ff <= ctx_in;
      res_ff <= res_in;
      out_ff <= out_in;
      samp_ff <= samp_in;
      need_div_ff <= need_div_in;
      need_area_ff <= need_area_in;
      area_ff <= 50'(ctx_in.width) * 50'(ctx_in.height);
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_pixel_value = out_ff.pixel;
   assign rsp_last_pixel = out_ff.last;
   assign rsp_image_width = out_ff.width;
   assign rsp_image_height = out_ff.height;
   assign rsp_error_code = out_ff.code;

`ifndef SYNTHESIS
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_READ))
      else $error("word accepted without starting read");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind)))
      else $error("stalled result lost");
   a_div_only: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");
`endif
endmodule
